FILE: rtl/pin_name_parser_unit_assert.svh
`ifndef PIN_NAME_PARSER_UNIT_ASSERT_SVH
`define PIN_NAME_PARSER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as the trigger.
`define PNP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after the trigger.
`define PNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pnp_pkg.sv
package pnp_pkg;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_BANKLET = 3'd1;
  localparam logic [2:0] PH_BANKDIG = 3'd2;
  localparam logic [2:0] PH_PFX1    = 3'd3;
  localparam logic [2:0] PH_PFX2    = 3'd4;
  localparam logic [2:0] PH_PFX3    = 3'd5;
  localparam logic [2:0] PH_PFX4    = 3'd6;
  localparam logic [2:0] PH_NUMDIG  = 3'd7;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_BANK_COUNT = 2'd1;
  localparam logic [1:0] REG_BANK_SIZE  = 2'd2;

  localparam logic [0:0]  MODE_RESET       = 1'b0;
  localparam logic [4:0]  BANK_COUNT_RESET = 5'd8;
  localparam logic [10:0] BANK_SIZE_RESET  = 11'd32;
  localparam logic [4:0]  MAX_BANKS        = 5'd26;

  localparam logic [24:0] NUM_LIMIT_P1 = 25'((1 << 20) + 1);

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_P = 8'h50;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_UPPER_G = 8'h47;
  localparam logic [7:0] CH_LOWER_G = 8'h67;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_O = 8'h6f;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic [2:0]  phase;
    logic [20:0] acc;
    logic [4:0]  bank_idx;
    logic        prefix_upper;
    logic        lead_zero;
    logic        digit_seen;
    logic        failed;
  } pnp_state_t;

  localparam pnp_state_t STATE_CLEAR = '{
    phase:        PH_START,
    acc:          21'd0,
    bank_idx:     5'd0,
    prefix_upper: 1'b0,
    lead_zero:    1'b0,
    digit_seen:   1'b0,
    failed:       1'b0
  };

endpackage

FILE: rtl/pin_name_parser_unit.sv
// Output: a result appears on the output register in the cycle after its last beat.
// Throughput: one character beat per cycle while in_ready is high (no result is held
// or it is being taken); the parse state, accumulator and result register all update on one clock edge.
// Reset (rst, synchronous): clears the parse state and output valid, and sets
// mode to bank naming, bank_count to 8 and bank_size to 32.
module pin_name_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [20:0] pin_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import pnp_pkg::*;

  `include "pin_name_parser_unit_assert.svh"

  logic        mode;
  logic [4:0]  bank_count;
  logic [10:0] bank_size;
  pnp_state_t  st;
  pnp_state_t  st_next;
  logic        res_ok;
  logic [20:0] res_pin;
  logic        in_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  pnp_step u_step (
    .st         (st),
    .character  (character),
    .mode       (mode),
    .bank_count (bank_count),
    .bank_size  (bank_size),
    .nxt        (st_next),
    .res_ok     (res_ok),
    .res_pin    (res_pin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RESET;
      bank_count <= BANK_COUNT_RESET;
      bank_size  <= BANK_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= cfg_data[0];
        REG_BANK_COUNT: bank_count <= cfg_data[4:0];
        REG_BANK_SIZE:  bank_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= last ? STATE_CLEAR : st_next;
      end
      if (in_fire && last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      ok         <= res_ok;
      pin_number <= res_pin;
    end
  end

  `PNP_ASSERT_NEXT(a_fail_sticky, in_fire && !last && st.failed, st.failed, "failed flag dropped mid-name")
  `PNP_ASSERT_NEXT(a_name_clear, in_fire && last, st.phase == PH_START && !st.failed && !st.digit_seen, "state not cleared after last beat")
  `PNP_ASSERT_NEXT(a_result_up, in_fire && last, out_valid, "no result after last beat")
  `PNP_ASSERT_NOW(a_fail_zero, out_valid && !ok, pin_number == 21'd0, "refused name carries a pin")

endmodule

FILE: rtl/pnp_step.sv
module pnp_step (
  input  pnp_pkg::pnp_state_t st,
  input  logic [7:0]          character,
  input  logic                mode,
  input  logic [4:0]          bank_count,
  input  logic [10:0]         bank_size,
  output pnp_pkg::pnp_state_t nxt,
  output logic                res_ok,
  output logic [20:0]         res_pin
);
  import pnp_pkg::*;

  logic        is_digit;
  logic [7:0]  dsub;
  logic [24:0] prod;
  logic [24:0] dval;
  logic [24:0] lim;
  logic        dig_fail;
  logic        is_lower;
  logic        is_upper;
  logic [7:0]  lsub;
  logic [7:0]  usub;
  logic [4:0]  bank_b;
  logic [4:0]  banks;
  logic [15:0] base_mul;
  logic [7:0]  pfx_want;
  logic [7:0]  pfx_lower;
  logic [20:0] bank_pin;

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign dsub     = character - CH_ZERO;
  assign prod     = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0};
  assign dval     = prod + {21'd0, dsub[3:0]};
  assign lim      = (st.phase == PH_BANKDIG) ? {14'd0, bank_size} : NUM_LIMIT_P1;
  assign dig_fail = !is_digit || (st.digit_seen && st.lead_zero) || (dval >= lim);

  assign is_lower = (character >= CH_LOWER_A) && (character <= CH_LOWER_Z);
  assign is_upper = (character >= CH_UPPER_A) && (character <= CH_UPPER_Z);
  assign lsub     = character - CH_LOWER_A;
  assign usub     = character - CH_UPPER_A;
  assign bank_b   = is_lower ? lsub[4:0] : usub[4:0];
  assign banks    = (bank_count > MAX_BANKS) ? MAX_BANKS : bank_count;
  assign base_mul = {11'd0, st.bank_idx} * {5'd0, bank_size};

  always_comb begin
    unique case (st.phase)
      PH_PFX1: pfx_lower = CH_LOWER_P;
      PH_PFX2: pfx_lower = CH_LOWER_I;
      default: pfx_lower = CH_LOWER_O;
    endcase
    pfx_want = st.prefix_upper ? (pfx_lower - CASE_DELTA) : pfx_lower;
  end

  always_comb begin
    logic take;
    take = 1'b0;
    nxt  = st;
    if (!st.failed) begin
      unique case (st.phase)
        PH_START: begin
          if (!mode) begin
            if ((character == CH_UPPER_P) || (character == CH_LOWER_P)) begin
              nxt.phase = PH_BANKLET;
            end else begin
              nxt.failed = 1'b1;
            end
          end else if (character == CH_LOWER_G) begin
            nxt.prefix_upper = 1'b0;
            nxt.phase        = PH_PFX1;
          end else if (character == CH_UPPER_G) begin
            nxt.prefix_upper = 1'b1;
            nxt.phase        = PH_PFX1;
          end else begin
            nxt.phase = PH_NUMDIG;
            take      = 1'b1;
          end
        end
        PH_BANKLET: begin
          if (!(is_lower || is_upper) || (bank_b >= banks)) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.bank_idx = bank_b;
            nxt.phase    = PH_BANKDIG;
          end
        end
        PH_PFX1, PH_PFX2, PH_PFX3: begin
          if (character == pfx_want) begin
            nxt.phase = st.phase + 3'd1;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        PH_PFX4: begin
          nxt.phase = PH_NUMDIG;
          take      = 1'b1;
        end
        PH_BANKDIG, PH_NUMDIG: begin
          take = 1'b1;
        end
        default: begin
          nxt.failed = 1'b1;
        end
      endcase
      if (take) begin
        if (dig_fail) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.acc        = dval[20:0];
          nxt.lead_zero  = st.lead_zero || (!st.digit_seen && (character == CH_ZERO));
          nxt.digit_seen = 1'b1;
        end
      end
    end
  end

  assign bank_pin = {5'd0, base_mul} + nxt.acc;
  assign res_ok   = !nxt.failed && nxt.digit_seen &&
                    ((nxt.phase == PH_BANKDIG) || (nxt.phase == PH_NUMDIG));
  assign res_pin  = !res_ok ? 21'd0 : ((nxt.phase == PH_BANKDIG) ? bank_pin : nxt.acc);

endmodule

FILE: dv/pin_name_parser_unit_check.sv
module pin_name_parser_unit_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  character,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        ok,
  input  logic [20:0] pin_number,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int unsigned PIN_CAP = 32'd1 << 20;

  typedef struct packed {
    logic        ok;
    logic [20:0] pin;
  } pin_result_t;

  pin_result_t expected_pins[$];

  logic        mode_q;
  logic [4:0]  nbanks;
  logic [10:0] bsize;

  logic [2:0]  ph;
  int unsigned acc;
  int unsigned bank;
  logic        pfx_up;
  logic        lead0;
  logic        dseen;
  logic        bad;

  task automatic restart_name();
    ph = PH_START;
    acc = 0;
    bank = 0;
    pfx_up = 1'b0;
    lead0 = 1'b0;
    dseen = 1'b0;
    bad = 1'b0;
  endtask

  task automatic take_digit(input logic [7:0] c, input int unsigned lim_p1);
    int unsigned v;
    if (c < "0" || c > "9") begin
      bad = 1'b1;
      return;
    end
    if (dseen && lead0) begin
      bad = 1'b1;
      return;
    end
    if (!dseen && c == "0") lead0 = 1'b1;
    v = acc * 10 + (c - "0");
    if (v >= lim_p1) begin
      bad = 1'b1;
      return;
    end
    acc = v;
    dseen = 1'b1;
  endtask

  task automatic take_prefix(input logic [7:0] c, input logic [7:0] lower,
                             input logic [2:0] nxt);
    logic [7:0] want;
    want = pfx_up ? lower - 8'h20 : lower;
    if (c == want) ph = nxt;
    else bad = 1'b1;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic lst);
    int unsigned banks;
    int unsigned b;
    pin_result_t res;
    banks = (nbanks > MAX_BANKS) ? MAX_BANKS : nbanks;
    if (!bad) begin
      case (ph)
        PH_START: begin
          if (!mode_q) begin
            if (c == "P" || c == "p") ph = PH_BANKLET;
            else bad = 1'b1;
          end else if (c == "g") begin
            pfx_up = 1'b0;
            ph = PH_PFX1;
          end else if (c == "G") begin
            pfx_up = 1'b1;
            ph = PH_PFX1;
          end else begin
            ph = PH_NUMDIG;
            take_digit(c, PIN_CAP + 1);
          end
        end
        PH_BANKLET: begin
          if (c >= "a" && c <= "z") b = c - "a";
          else if (c >= "A" && c <= "Z") b = c - "A";
          else b = 32;
          if (b >= banks) bad = 1'b1;
          else begin
            bank = b;
            ph = PH_BANKDIG;
          end
        end
        PH_BANKDIG: take_digit(c, bsize);
        PH_PFX1: take_prefix(c, "p", PH_PFX2);
        PH_PFX2: take_prefix(c, "i", PH_PFX3);
        PH_PFX3: take_prefix(c, "o", PH_PFX4);
        PH_PFX4: begin
          ph = PH_NUMDIG;
          take_digit(c, PIN_CAP + 1);
        end
        PH_NUMDIG: take_digit(c, PIN_CAP + 1);
        default: bad = 1'b1;
      endcase
    end
    if (lst) begin
      res.ok = !bad && dseen && (ph == PH_BANKDIG || ph == PH_NUMDIG);
      res.pin = '0;
      if (res.ok) res.pin = (ph == PH_BANKDIG) ? 21'(bank * bsize + acc) : 21'(acc);
      expected_pins.push_back(res);
      restart_name();
    end
  endtask

  always @(posedge clk) begin
    pin_result_t want;
    if (rst) begin
      mode_q = MODE_RESET;
      nbanks = BANK_COUNT_RESET;
      bsize = BANK_SIZE_RESET;
      restart_name();
      expected_pins.delete();
    end else begin
      if (in_valid && in_ready) parse_char(character, last);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: mode_q = cfg_data[0];
          REG_BANK_COUNT: nbanks = cfg_data[4:0];
          REG_BANK_SIZE: bsize = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result ok=%0b pin=%0d", $realtime, ok, pin_number);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          checked++;
          if (ok !== want.ok || pin_number !== want.pin) begin
            if (mismatches < 10)
              $display("%0t: result mismatch ok exp %0b got %0b, pin exp %0d got %0d",
                       $realtime, want.ok, ok, want.pin, pin_number);
            mismatches++;
          end
        end
      end
    end
    pending = expected_pins.size();
  end

endmodule

FILE: dv/pin_name_parser_unit_test.sv
module pin_name_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pnp_pkg::*;

  localparam int unsigned PIN_CAP = 32'd1 << 20;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  character = 8'h00;
  logic        last = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_MODE;
  logic [10:0] cfg_data = 11'd0;
  logic        in_ready;
  logic        out_valid;
  logic        ok;
  logic [20:0] pin_number;
  logic        cfg_ready;

  int mismatches;
  int pending;
  int checked;

  logic [7:0]  name_buf[$];
  int unsigned cur_banks;
  int unsigned cur_size;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          names_sent = 0;
  int          chars_sent = 0;
  int          settings_used = 1;
  int          pat = 0;
  int          pat_left = 0;

  pin_name_parser_unit uut (.*);

  pin_name_parser_unit_check result_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL pin_name_parser_unit");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(20, 120);
      pat <= $urandom_range(0, 3);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (pat)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (pat_left % 3 == 0);
    endcase
  end

  task automatic send_beat(input logic [7:0] c, input logic l);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    character <= c;
    last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_beat(name_buf[i], i == name_buf.size() - 1);
    names_sent++;
  endtask

  task automatic send_text(input string s);
    name_buf.delete();
    foreach (s[i]) name_buf.push_back(s[i]);
    send_name();
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic m, input logic [4:0] cnt, input logic [10:0] sz);
    settle();
    write_reg(REG_MODE, 11'(m));
    write_reg(REG_BANK_COUNT, 11'(cnt));
    write_reg(REG_BANK_SIZE, sz);
    cur_banks = (cnt > MAX_BANKS) ? MAX_BANKS : cnt;
    cur_size = sz;
    settings_used++;
  endtask

  task automatic make_name(input logic numeric);
    int unsigned r;
    int unsigned v;
    int unsigned k;
    string digits;
    name_buf.delete();
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (!numeric) begin
      name_buf.push_back($urandom_range(0, 1) ? "P" : "p");
      v = (cur_banks > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, cur_banks - 1)
                                                        : $urandom_range(0, 25);
      name_buf.push_back(8'(($urandom_range(0, 1) ? "A" : "a") + v));
      v = (cur_size == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(cur_size, cur_size + 9)
                                                       : $urandom_range(0, cur_size - 1);
    end else begin
      case ($urandom_range(0, 2))
        1: begin
          name_buf.push_back("g"); name_buf.push_back("p");
          name_buf.push_back("i"); name_buf.push_back("o");
        end
        2: begin
          name_buf.push_back("G"); name_buf.push_back("P");
          name_buf.push_back("I"); name_buf.push_back("O");
        end
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 9);
        1: v = $urandom_range(0, 99999);
        2: v = $urandom_range(0, PIN_CAP);
        3: v = $urandom_range(PIN_CAP - 6, PIN_CAP + 6);
        default: v = $urandom();
      endcase
    end
    if ($urandom_range(0, 15) == 0) name_buf.push_back("0");
    digits = $sformatf("%0d", v);
    foreach (digits[i]) name_buf.push_back(digits[i]);
    case (r)
      1: begin
        k = $urandom_range(1, name_buf.size() - 1);
        while (name_buf.size() > k) void'(name_buf.pop_back());
      end
      2: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
      3: begin
        k = $urandom_range(0, (name_buf.size() > 4) ? 3 : name_buf.size() - 1);
        name_buf[k] = name_buf[k] ^ 8'h20;
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic m, input logic [4:0] cnt, input logic [10:0] sz,
                           input int quota);
    int start;
    set_regs(m, cnt, sz);
    start = chars_sent;
    while (chars_sent - start < quota) begin
      make_name(m);
      send_name();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cur_banks = BANK_COUNT_RESET;
    cur_size = BANK_SIZE_RESET;

    send_text("pa0");
    send_text("PH31");
    send_text("PI1");
    send_text("P");
    send_text("Pb");
    send_text("PB01");
    name_buf = '{8'hFF};
    send_name();

    set_regs(1'b1, BANK_COUNT_RESET, BANK_SIZE_RESET);
    send_text("1048576");
    send_text("1048577");
    send_text("gpio0");
    send_text("GPIO");
    send_text("GpIO5");
    send_text("0");
    send_text("00");
    name_buf = '{8'h00};
    send_name();

    run_phase(1'b1, 5'd8, 11'd32, 130);
    run_phase(1'b0, 5'd1, 11'd1, 100);
    run_phase(1'b0, 5'd26, 11'd1024, 130);
    run_phase(1'b1, 5'd26, 11'd1024, 130);
    run_phase(1'b0, 5'd0, 11'd32, 60);
    run_phase(1'b0, 5'd31, 11'd2047, 130);
    run_phase(1'b0, 5'd8, 11'd0, 60);
    run_phase(1'b0, 5'($urandom_range(1, 26)), 11'($urandom_range(1, 1024)), 130);
    run_phase(1'b1, 5'($urandom_range(1, 26)), 11'($urandom_range(1, 1024)), 130);
    run_phase(1'b0, 5'($urandom_range(1, 26)), 11'($urandom_range(1, 1024)), 130);

    settle();
    $display("Sent %0d names (%0d character beats) over %0d register settings;",
             names_sent, chars_sent, settings_used);
    $display("checked %0d results, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS pin_name_parser_unit");
    end else begin
      $display("FAIL pin_name_parser_unit");
    end
    $finish;
  end

endmodule
